[rtl/sha1_pkg.sv]
// Shared types and constants of the SHA-1 message digest core.
`default_nettype none
package sha1_pkg;
	localparam logic [31:0] H0_INIT = 32'h67452301;
	localparam logic [31:0] H1_INIT = 32'hEFCDAB89;
	localparam logic [31:0] H2_INIT = 32'h98BADCFE;
	localparam logic [31:0] H3_INIT = 32'h10325476;
	localparam logic [31:0] H4_INIT = 32'hC3D2E1F0;
	localparam logic [31:0] K0 = 32'h5A827999;
	localparam logic [31:0] K1 = 32'h6ED9EBA1;
	localparam logic [31:0] K2 = 32'h8F1BBCDC;
	localparam logic [31:0] K3 = 32'hCA62C1D6;
	localparam logic [7:0] PAD_BYTE = 8'h80;
	localparam logic [6:0] LAST_ROUND = 7'd79;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic       put_byte;   // write data byte at current position
		logic       put_pad;    // write 0x80 at current position
		logic       put_zero;   // write 0x00 at current position
		logic       put_len;    // write bit length into words 14 and 15
		logic       clear_blk;  // zero all block words
		logic       start;      // load working variables from hash words
		logic       round;      // execute one round
		logic       finish;     // add working variables into hash words
		logic       reinit;     // restore initial hash, clear length
		logic       cnt_inc;    // advance byte counter
		logic       pos_inc;    // advance fill position only
		logic [2:0] out_sel;    // digest word to present
	} sha1_cmd_t;

	typedef struct packed {
		logic [5:0] pos;        // fill position in block
		logic       last_round;
		logic [31:0] out_word;
	} sha1_sts_t;
endpackage
`default_nettype wire

[rtl/sha1_datapath.sv]
// Datapath of the SHA-1 core: block buffer, round logic, hash state and length.
`default_nettype none
module sha1_datapath import sha1_pkg::*; (
	input  wire        clk,
	input  wire        arst_n,
	input  wire [7:0]  data_byte,
	input  sha1_cmd_t  cmd,
	output sha1_sts_t  sts
);
	logic [31:0] blk_q [16];
	logic [31:0] h_q [5];
	logic [31:0] a_q, b_q, c_q, d_q, e_q;
	logic [60:0] cnt_q;
	logic [5:0]  pos_q;
	logic [6:0]  rnd_q;

	logic [7:0]  wr_byte;
	logic [31:0] w, fn, kc, tmp, wx;
	logic [3:0]  ri;
	logic [63:0] bits;

	assign ri = rnd_q[3:0];
	assign bits = {cnt_q, 3'b000};
	assign wx = blk_q[ri + 4'd13] ^ blk_q[ri + 4'd8] ^ blk_q[ri + 4'd2] ^ blk_q[ri];

	always_comb begin
		wr_byte = cmd.put_pad ? PAD_BYTE : (cmd.put_zero ? 8'h00 : data_byte);
		w = (rnd_q < 7'd16) ? blk_q[ri] : {wx[30:0], wx[31]};
		if (rnd_q < 7'd20) begin
			fn = (b_q & c_q) | (~b_q & d_q);
			kc = K0;
		end else if (rnd_q < 7'd40) begin
			fn = b_q ^ c_q ^ d_q;
			kc = K1;
		end else if (rnd_q < 7'd60) begin
			fn = (b_q & c_q) | (b_q & d_q) | (c_q & d_q);
			kc = K2;
		end else begin
			fn = b_q ^ c_q ^ d_q;
			kc = K3;
		end
		tmp = {a_q[26:0], a_q[31:27]} + fn + e_q + w + kc;
	end

	// Block buffer; it also holds the rolling message schedule.
	always_ff @(posedge clk) begin
		if (cmd.clear_blk) begin
			for (int i = 0; i < 16; i++) blk_q[i] <= '0;
		end else if (cmd.put_len) begin
			blk_q[14] <= bits[63:32];
			blk_q[15] <= bits[31:0];
		end else if (cmd.put_byte || cmd.put_pad || cmd.put_zero) begin
			unique case (pos_q[1:0])
				2'd0: blk_q[pos_q[5:2]] <= {wr_byte, 24'h0};
				2'd1: blk_q[pos_q[5:2]][23:16] <= wr_byte;
				2'd2: blk_q[pos_q[5:2]][15:8] <= wr_byte;
				2'd3: blk_q[pos_q[5:2]][7:0] <= wr_byte;
				default: ;
			endcase
		end else if (cmd.round && rnd_q >= 7'd16) begin
			blk_q[ri] <= w;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			h_q[0] <= H0_INIT; h_q[1] <= H1_INIT; h_q[2] <= H2_INIT;
			h_q[3] <= H3_INIT; h_q[4] <= H4_INIT;
			{a_q, b_q, c_q, d_q, e_q} <= '0;
			cnt_q <= '0;
			pos_q <= '0;
			rnd_q <= '0;
		end else begin
			if (cmd.reinit) begin
				h_q[0] <= H0_INIT; h_q[1] <= H1_INIT; h_q[2] <= H2_INIT;
				h_q[3] <= H3_INIT; h_q[4] <= H4_INIT;
				cnt_q <= '0;
				pos_q <= '0;
			end else if (cmd.finish) begin
				h_q[0] <= h_q[0] + a_q; h_q[1] <= h_q[1] + b_q;
				h_q[2] <= h_q[2] + c_q; h_q[3] <= h_q[3] + d_q;
				h_q[4] <= h_q[4] + e_q;
			end
			if (cmd.cnt_inc) begin
				cnt_q <= cnt_q + 61'd1;
				pos_q <= pos_q + 6'd1;
			end else if (cmd.pos_inc) begin
				pos_q <= pos_q + 6'd1;
			end
			if (cmd.start) begin
				a_q <= h_q[0]; b_q <= h_q[1]; c_q <= h_q[2];
				d_q <= h_q[3]; e_q <= h_q[4];
				rnd_q <= '0;
			end else if (cmd.round) begin
				a_q <= tmp; b_q <= a_q; c_q <= {b_q[1:0], b_q[31:2]};
				d_q <= c_q; e_q <= d_q;
				rnd_q <= (rnd_q == LAST_ROUND) ? 7'd0 : rnd_q + 7'd1;
			end
		end
	end

	assign sts.pos = pos_q;
	assign sts.last_round = (rnd_q == LAST_ROUND);
	assign sts.out_word = (cmd.out_sel <= 3'd4) ? h_q[cmd.out_sel] : 32'h0;
endmodule
`default_nettype wire

[rtl/sha1_ctrl.sv]
// Controller of the SHA-1 core: input handshake, padding sequence, rounds, output.
`default_nettype none
module sha1_ctrl import sha1_pkg::*; (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        in_valid,
	output logic       in_ready,
	input  wire        has_byte,
	input  wire        end_of_message,
	output logic       out_valid,
	input  wire        out_ready,
	output logic [2:0] out_idx,
	output sha1_cmd_t  cmd,
	input  sha1_sts_t  sts
);
	typedef enum logic [7:0] {
		S_IDLE  = 8'b00000001,
		S_START = 8'b00000010,
		S_ROUND = 8'b00000100,
		S_PAD   = 8'b00001000,
		S_ZERO  = 8'b00010000,
		S_LEN   = 8'b00100000,
		S_OUT   = 8'b01000000,
		S_FIN   = 8'b10000000
	} state_t;

	state_t st_q, st_d;
	logic fin_q, fin_d;     // padding pending after the current compression
	logic final_q, final_d; // the compression under way is the last one
	logic [2:0] idx_q, idx_d;
	logic acc;

	assign acc = in_valid && in_ready;
	assign in_ready = (st_q == S_IDLE);
	assign out_valid = (st_q == S_OUT);
	assign out_idx = idx_q;

	always_comb begin
		st_d = st_q; fin_d = fin_q; final_d = final_q; idx_d = idx_q;
		cmd = '0;
		cmd.out_sel = idx_q;
		unique case (st_q)
			S_IDLE: begin
				if (acc) begin
					fin_d = end_of_message;
					final_d = 1'b0;
					if (has_byte) begin
						cmd.put_byte = 1'b1;
						cmd.cnt_inc = 1'b1;
					end
					if (has_byte && sts.pos == 6'd63) st_d = S_START;
					else if (end_of_message) st_d = S_PAD;
				end
			end
			S_PAD: begin
				cmd.put_pad = 1'b1;
				cmd.pos_inc = 1'b1;
				fin_d = 1'b0;
				if (sts.pos == 6'd63) st_d = S_START;
				else if (sts.pos >= 6'd56) st_d = S_ZERO;
				else st_d = (sts.pos == 6'd55) ? S_LEN : S_ZERO;
			end
			S_ZERO: begin
				cmd.put_zero = 1'b1;
				cmd.pos_inc = 1'b1;
				if (sts.pos == 6'd63) st_d = S_START;
				else if (sts.pos == 6'd55) st_d = S_LEN;
			end
			S_LEN: begin
				cmd.put_len = 1'b1;
				final_d = 1'b1;
				st_d = S_START;
			end
			S_START: begin
				cmd.start = 1'b1;
				st_d = S_ROUND;
			end
			S_ROUND: begin
				cmd.round = 1'b1;
				if (sts.last_round) st_d = S_FIN;
			end
			S_FIN: begin
				cmd.finish = 1'b1;
				if (final_q) begin
					idx_d = '0;
					st_d = S_OUT;
				end else if (fin_q) begin
					st_d = S_PAD;
				end else if (sts.pos == 6'd0 && idx_q == 3'd7) begin
					// Second padding block: zeros up to the length field.
					cmd.clear_blk = 1'b1;
					idx_d = '0;
					st_d = S_LEN;
				end else begin
					st_d = S_IDLE;
				end
			end
			S_OUT: begin
				if (out_ready) begin
					if (idx_q == 3'd4) begin
						cmd.reinit = 1'b1;
						st_d = S_IDLE;
					end
					idx_d = idx_q + 3'd1;
				end
			end
			default: st_d = S_IDLE;
		endcase
		// A pad that spilled past the length field needs a second block.
		if (st_q == S_ZERO && sts.pos == 6'd63) idx_d = 3'd7;
		if (st_q == S_PAD && sts.pos >= 6'd56) idx_d = 3'd7;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			fin_q <= 1'b0;
			final_q <= 1'b0;
			idx_q <= '0;
		end else begin
			st_q <= st_d;
			fin_q <= fin_d;
			final_q <= final_d;
			idx_q <= idx_d;
		end
	end
endmodule
`default_nettype wire

[rtl/sha1_message_digest_core.sv]
// Top level of the SHA-1 message digest core.
// Input: a byte is taken while the core is idle; a full block starts a compression.
// Throughput: one byte per cycle between blocks; s_tready is low while compressing,
// which is done by the single round unit running 80 rounds per block.
// At message end, padding adds one or two compressions.
// Reset is asynchronous, active low, and restores the initial hash values.
`default_nettype none
module sha1_message_digest_core import sha1_pkg::*; (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        s_tvalid,
	output logic       s_tready,
	input  wire [7:0]  s_tdata,   // data_byte
	input  wire        s_tuser,   // has_byte
	input  wire        s_tlast,   // end_of_message
	output logic       m_tvalid,
	input  wire        m_tready,
	output logic [39:0] m_tdata,  // digest_word[31:0], word_index[34:32], zeros
	output logic       m_tlast    // last_word
);
	sha1_cmd_t cmd;
	sha1_sts_t sts;
	logic [2:0] idx;

	sha1_ctrl u_ctrl (
		.clk, .arst_n,
		.in_valid(s_tvalid), .in_ready(s_tready),
		.has_byte(s_tuser), .end_of_message(s_tlast),
		.out_valid(m_tvalid), .out_ready(m_tready), .out_idx(idx),
		.cmd, .sts
	);

	sha1_datapath u_dp (
		.clk, .arst_n, .data_byte(s_tdata), .cmd, .sts
	);

	assign m_tdata = {5'b0, idx, sts.out_word};
	assign m_tlast = (idx == 3'd4);
endmodule
`default_nettype wire

[rtl/sha1_checker.sv]
// Port-level checker for the SHA-1 core, bound to the top level.
`default_nettype none
module sha1_checker (
	input wire        clk,
	input wire        arst_n,
	input wire        s_tready,
	input wire        m_tvalid,
	input wire        m_tready,
	input wire [39:0] m_tdata,
	input wire        m_tlast
);
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[34:32] <= 3'd4) else $error("word index out of range");
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tlast == (m_tdata[34:32] == 3'd4))) else $error("last flag wrong");
	a_no_in_during_out: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !s_tready) else $error("input open during output");
	a_next_idx: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && !m_tlast |=> m_tvalid)
		else $error("digest words not contiguous");
endmodule

bind sha1_message_digest_core sha1_checker u_chk (
	.clk, .arst_n, .s_tready, .m_tvalid, .m_tready, .m_tdata, .m_tlast
);
`default_nettype wire
